[hdl/rrb_pkg.sv]
package rrb_pkg;

    localparam int unsigned DEPTH_DEF = 2048;
    localparam int unsigned LEVEL_W   = 12;
    localparam int unsigned CFG_W     = 12;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned BYTE_W    = 8;

    localparam logic [LEVEL_W-1:0] XOFF_LEVEL_RST = 12'd1920;
    localparam logic [LEVEL_W-1:0] XON_LEVEL_RST  = 12'd128;

    localparam logic [BYTE_W-1:0] CHAR_XOFF = 8'h13;
    localparam logic [BYTE_W-1:0] CHAR_XON  = 8'h11;

    typedef enum logic [1:0] {
        MODE_STORE = 2'd0,
        MODE_READ  = 2'd1,
        MODE_FLUSH = 2'd2,
        MODE_NOP   = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FLOW_ENABLE = 2'd0,
        CFG_XOFF_LEVEL  = 2'd1,
        CFG_XON_LEVEL   = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

endpackage

[hdl/rx_ring_buffer_xon_xoff.sv]
// o_done strobes the result after the EXEC state has registered it. A new item
// is taken only from IDLE, not while the last one is in EXEC. The item is
// latched, then the index, count and flow flags update while the byte memory
// is written or read.
// o_busy is high in the update cycle. The receiver cannot stall results.
// Reset (synchronous, active low) empties the buffer, clears the XOFF flag
// and restores the flow registers; buffer contents are not cleared.
module rx_ring_buffer_xon_xoff #(
    parameter int unsigned DEPTH = rrb_pkg::DEPTH_DEF,
    localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    output logic                          o_done,
    input  logic [1:0]                    i_mode,
    input  logic [rrb_pkg::BYTE_W-1:0]    i_rx_byte,
    input  logic                          i_cfg_we,
    input  logic [rrb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rrb_pkg::CFG_W-1:0]     i_cfg_data,
    output logic [rrb_pkg::BYTE_W-1:0]    o_read_byte,
    output logic                          o_read_valid,
    output logic [rrb_pkg::BYTE_W-1:0]    o_flow_char,
    output logic                          o_flow_valid,
    output logic [CW-1:0]                 o_fill_count,
    output logic                          o_overflow
);

    rrb_pkg::t_dp_cmd cmd;

    rrb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .o_done  (o_done),
        .o_cmd   (cmd)
    );

    rrb_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_mode       (i_mode),
        .i_rx_byte    (i_rx_byte),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_read_byte  (o_read_byte),
        .o_read_valid (o_read_valid),
        .o_flow_char  (o_flow_char),
        .o_flow_valid (o_flow_valid),
        .o_fill_count (o_fill_count),
        .o_overflow   (o_overflow)
    );

endmodule

[hdl/rrb_ctrl.sv]
module rrb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    output logic             o_done,
    output rrb_pkg::t_dp_cmd o_cmd
);

    rrb_pkg::t_state r_state;
    rrb_pkg::t_state n_state;
    logic            r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rrb_pkg::S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= o_cmd.exec;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd.load = 1'b0;
        o_cmd.exec = 1'b0;
        unique case (r_state)
            rrb_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = rrb_pkg::S_EXEC;
                end
            end
            rrb_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = rrb_pkg::S_IDLE;
            end
            default: n_state = rrb_pkg::S_IDLE;
        endcase
    end

    assign o_busy = (r_state == rrb_pkg::S_EXEC);
    assign o_done = r_done;

endmodule

[hdl/rrb_datapath.sv]
module rrb_datapath #(
    parameter int unsigned DEPTH = rrb_pkg::DEPTH_DEF,
    localparam int unsigned IW   = $clog2(DEPTH),
    localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rrb_pkg::t_dp_cmd              i_cmd,
    input  logic [1:0]                    i_mode,
    input  logic [rrb_pkg::BYTE_W-1:0]    i_rx_byte,
    input  logic                          i_cfg_we,
    input  logic [rrb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rrb_pkg::CFG_W-1:0]     i_cfg_data,
    output logic [rrb_pkg::BYTE_W-1:0]    o_read_byte,
    output logic                          o_read_valid,
    output logic [rrb_pkg::BYTE_W-1:0]    o_flow_char,
    output logic                          o_flow_valid,
    output logic [CW-1:0]                 o_fill_count,
    output logic                          o_overflow
);

    localparam int unsigned CMPW = (CW > rrb_pkg::LEVEL_W) ? CW : rrb_pkg::LEVEL_W;

    logic [rrb_pkg::BYTE_W-1:0] r_mem [DEPTH];
    logic [rrb_pkg::BYTE_W-1:0] r_mem_q;

    rrb_pkg::t_mode              r_mode;
    logic [rrb_pkg::BYTE_W-1:0]  r_rx;

    logic                        r_flow_en;
    logic [rrb_pkg::LEVEL_W-1:0] r_xoff_level;
    logic [rrb_pkg::LEVEL_W-1:0] r_xon_level;

    logic [IW-1:0] r_wr_idx, n_wr_idx;
    logic [IW-1:0] r_rd_idx, n_rd_idx;
    logic [CW-1:0] r_held,   n_held;
    logic          r_xoff_sent, n_xoff_sent;

    logic                       r_read_valid, n_read_valid;
    logic [rrb_pkg::BYTE_W-1:0] r_flow_char,  n_flow_char;
    logic                       r_flow_valid, n_flow_valid;
    logic                       r_overflow,   n_overflow;

    logic          mem_we;
    logic          mem_re;
    logic          full;
    logic [CW-1:0] cnt_after;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= rrb_pkg::t_mode'(i_mode);
            r_rx   <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flow_en    <= 1'b0;
            r_xoff_level <= rrb_pkg::XOFF_LEVEL_RST;
            r_xon_level  <= rrb_pkg::XON_LEVEL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rrb_pkg::CFG_FLOW_ENABLE: r_flow_en    <= i_cfg_data[0];
                rrb_pkg::CFG_XOFF_LEVEL:  r_xoff_level <= i_cfg_data[rrb_pkg::LEVEL_W-1:0];
                rrb_pkg::CFG_XON_LEVEL:   r_xon_level  <= i_cfg_data[rrb_pkg::LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        full      = (r_held == CW'(DEPTH));
        cnt_after = full ? r_held : r_held + CW'(1);

        n_wr_idx     = r_wr_idx;
        n_rd_idx     = r_rd_idx;
        n_held       = r_held;
        n_xoff_sent  = r_xoff_sent;
        n_read_valid = 1'b0;
        n_flow_char  = '0;
        n_flow_valid = 1'b0;
        n_overflow   = 1'b0;
        mem_we       = 1'b0;
        mem_re       = 1'b0;

        unique case (r_mode)
            rrb_pkg::MODE_STORE: begin
                if (full) begin
                    n_overflow = 1'b1;
                end else begin
                    mem_we   = 1'b1;
                    n_wr_idx = (r_wr_idx == IW'(DEPTH - 1)) ? '0 : r_wr_idx + IW'(1);
                    n_held   = cnt_after;
                end
                if (r_flow_en && !r_xoff_sent
                    && (CMPW'(cnt_after) > CMPW'(r_xoff_level))) begin
                    n_flow_char  = rrb_pkg::CHAR_XOFF;
                    n_flow_valid = 1'b1;
                    n_xoff_sent  = 1'b1;
                end
            end
            rrb_pkg::MODE_READ: begin
                // XON is checked against the fill count before the read, even on an empty buffer
                if (r_xoff_sent && (CMPW'(r_held) < CMPW'(r_xon_level))) begin
                    n_flow_char  = rrb_pkg::CHAR_XON;
                    n_flow_valid = 1'b1;
                    n_xoff_sent  = 1'b0;
                end
                if (r_held != '0) begin
                    mem_re       = 1'b1;
                    n_read_valid = 1'b1;
                    n_rd_idx     = (r_rd_idx == IW'(DEPTH - 1)) ? '0 : r_rd_idx + IW'(1);
                    n_held       = r_held - CW'(1);
                end
            end
            rrb_pkg::MODE_FLUSH: begin
                if (r_xoff_sent) begin
                    n_flow_char  = rrb_pkg::CHAR_XON;
                    n_flow_valid = 1'b1;
                    n_xoff_sent  = 1'b0;
                end
                n_wr_idx = '0;
                n_rd_idx = '0;
                n_held   = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx    <= '0;
            r_rd_idx    <= '0;
            r_held      <= '0;
            r_xoff_sent <= 1'b0;
        end else if (i_cmd.exec) begin
            r_wr_idx    <= n_wr_idx;
            r_rd_idx    <= n_rd_idx;
            r_held      <= n_held;
            r_xoff_sent <= n_xoff_sent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_read_valid <= n_read_valid;
            r_flow_char  <= n_flow_char;
            r_flow_valid <= n_flow_valid;
            r_overflow   <= n_overflow;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && mem_we) begin
            r_mem[r_wr_idx] <= r_rx;
        end
        if (i_cmd.exec && mem_re) begin
            r_mem_q <= r_mem[r_rd_idx];
        end
    end

    assign o_read_byte  = r_read_valid ? r_mem_q : '0;
    assign o_read_valid = r_read_valid;
    assign o_flow_char  = r_flow_char;
    assign o_flow_valid = r_flow_valid;
    assign o_fill_count = r_held;
    assign o_overflow   = r_overflow;

endmodule
